// ===== rtl/ip_address_text_validator_assert.svh =====
`ifndef IP_ADDRESS_TEXT_VALIDATOR_ASSERT_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IATV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iatv assertion failed");

// next-cycle implication, checked outside reset
`define IATV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iatv assertion failed");

`endif

// ===== rtl/iatv_pkg.sv =====
package iatv_pkg;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;

   localparam logic [1:0] VERDICT_NONE = 2'd0;
   localparam logic [1:0] VERDICT_QUAD = 2'd1;
   localparam logic [1:0] VERDICT_HEX  = 2'd2;

   localparam logic [8:0]  QUAD_MAX_VALUE = 9'd255;
   localparam logic [8:0]  QUAD_VALUE_SAT = 9'd256;
   localparam logic [2:0]  QUAD_GROUPS    = 3'd4;
   localparam logic [2:0]  QUAD_GROUP_SAT = 3'd5;
   localparam logic [2:0]  QUAD_DIGIT_MAX = 3'd3;
   localparam logic [2:0]  QUAD_DIGIT_SAT = 3'd4;
   localparam logic [3:0]  HEX_GROUPS     = 4'd8;
   localparam logic [3:0]  HEX_GROUP_SAT  = 4'd9;
   localparam logic [2:0]  HEX_DIGIT_MAX  = 3'd4;
   localparam logic [2:0]  HEX_DIGIT_SAT  = 3'd5;

   typedef struct packed {
      logic       is_dot;
      logic       is_colon;
      logic       is_dec;
      logic       is_hex;
      logic [3:0] digit;
      logic       last;
   } token_type;

endpackage

// ===== rtl/iatv_front.sv =====
module iatv_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   input  logic               req_last_char,
   output logic               tok_valid,
   input  logic               tok_ready,
   output iatv_pkg::token_type tok
);

   iatv_pkg::token_type tok_ff, tok_in;
   logic                tok_valid_ff, tok_valid_in;

   always_comb begin
      tok_in          = '0;
      tok_in.is_dot   = (req_char_code == iatv_pkg::CHAR_DOT);
      tok_in.is_colon = (req_char_code == iatv_pkg::CHAR_COLON);
      tok_in.is_dec   = req_char_code inside {[iatv_pkg::CHAR_ZERO : iatv_pkg::CHAR_NINE]};
      tok_in.is_hex   = req_char_code inside {[iatv_pkg::CHAR_ZERO : iatv_pkg::CHAR_NINE],
                                              [iatv_pkg::CHAR_UA : iatv_pkg::CHAR_UF],
                                              [iatv_pkg::CHAR_LA : iatv_pkg::CHAR_LF]};
      tok_in.digit    = req_char_code[3:0];
      tok_in.last     = req_last_char;
   end

   assign req_ready = !tok_valid_ff || tok_ready;

   always_comb begin
      tok_valid_in = tok_valid_ff;
      if (req_ready) begin
         tok_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_valid = tok_valid_ff;
   assign tok       = tok_ff;

endmodule

// ===== rtl/iatv_queue.sv =====
`include "ip_address_text_validator_assert.svh"

module iatv_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  iatv_pkg::token_type push_tok,
   output logic                pop_valid,
   input  logic                pop_ready,
   output iatv_pkg::token_type pop_tok
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   iatv_pkg::token_type slot_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != CntFull);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_tok    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_tok;
      end
   end

   `IATV_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CntFull)
   `IATV_ASSERT_NEXT(a_count_track, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// ===== rtl/iatv_back.sv =====
`include "ip_address_text_validator_assert.svh"

module iatv_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                tok_valid,
   output logic                tok_ready,
   input  iatv_pkg::token_type tok,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_verdict
);

   logic       dot_seen_ff, dot_seen_in;
   logic       colon_seen_ff, colon_seen_in;
   logic       quad_ok_ff, quad_ok_in;
   logic [2:0] quad_groups_ff, quad_groups_in;
   logic [2:0] quad_digits_ff, quad_digits_in;
   logic [8:0] quad_value_ff, quad_value_in;
   logic       quad_first_zero_ff, quad_first_zero_in;
   logic       hex_ok_ff, hex_ok_in;
   logic [3:0] hex_groups_ff, hex_groups_in;
   logic [2:0] hex_digits_ff, hex_digits_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_verdict_ff, rsp_verdict_in;
   logic       take;

   assign tok_ready = !rsp_valid_ff || rsp_ready;
   assign take      = tok_valid && tok_ready;

   always_comb begin
      logic [11:0] acc;
      logic [1:0]  verdict;

      dot_seen_in        = dot_seen_ff;
      colon_seen_in      = colon_seen_ff;
      quad_ok_in         = quad_ok_ff;
      quad_groups_in     = quad_groups_ff;
      quad_digits_in     = quad_digits_ff;
      quad_value_in      = quad_value_ff;
      quad_first_zero_in = quad_first_zero_ff;
      hex_ok_in          = hex_ok_ff;
      hex_groups_in      = hex_groups_ff;
      hex_digits_in      = hex_digits_ff;
      acc                = {quad_value_ff, 3'b000} + {2'b00, quad_value_ff, 1'b0}
                           + {8'h00, tok.digit};
      verdict            = iatv_pkg::VERDICT_NONE;

      if (tok.is_dot) begin
         dot_seen_in = 1'b1;
      end
      if (tok.is_colon) begin
         colon_seen_in = 1'b1;
      end

      // dotted-quad reading
      if (tok.is_dot) begin
         if (quad_digits_in == '0 || quad_value_in > iatv_pkg::QUAD_MAX_VALUE) begin
            quad_ok_in = 1'b0;
         end
         if (quad_groups_in < iatv_pkg::QUAD_GROUP_SAT) begin
            quad_groups_in = quad_groups_in + 1'b1;
         end
         quad_digits_in     = '0;
         quad_value_in      = '0;
         quad_first_zero_in = 1'b0;
      end else if (tok.is_dec) begin
         if (quad_digits_ff == '0) begin
            quad_first_zero_in = (tok.digit == '0);
         end else if (quad_first_zero_ff) begin
            quad_ok_in = 1'b0;
         end
         if (quad_digits_ff < iatv_pkg::QUAD_DIGIT_SAT) begin
            quad_digits_in = quad_digits_ff + 1'b1;
         end
         if (quad_digits_in > iatv_pkg::QUAD_DIGIT_MAX) begin
            quad_ok_in = 1'b0;
         end
         quad_value_in = (acc > {3'b000, iatv_pkg::QUAD_VALUE_SAT}) ?
                         iatv_pkg::QUAD_VALUE_SAT : acc[8:0];
      end else begin
         quad_ok_in = 1'b0;
      end

      // colon-hex reading
      if (tok.is_colon) begin
         if (hex_digits_in == '0) begin
            hex_ok_in = 1'b0;
         end
         if (hex_groups_in < iatv_pkg::HEX_GROUP_SAT) begin
            hex_groups_in = hex_groups_in + 1'b1;
         end
         hex_digits_in = '0;
      end else if (tok.is_hex) begin
         if (hex_digits_ff < iatv_pkg::HEX_DIGIT_SAT) begin
            hex_digits_in = hex_digits_ff + 1'b1;
         end
         if (hex_digits_in > iatv_pkg::HEX_DIGIT_MAX) begin
            hex_ok_in = 1'b0;
         end
      end else begin
         hex_ok_in = 1'b0;
      end

      // end of string: close open groups and judge
      if (tok.last) begin
         if (quad_digits_in == '0 || quad_value_in > iatv_pkg::QUAD_MAX_VALUE) begin
            quad_ok_in = 1'b0;
         end
         if (quad_groups_in < iatv_pkg::QUAD_GROUP_SAT) begin
            quad_groups_in = quad_groups_in + 1'b1;
         end
         if (hex_digits_in == '0) begin
            hex_ok_in = 1'b0;
         end
         if (hex_groups_in < iatv_pkg::HEX_GROUP_SAT) begin
            hex_groups_in = hex_groups_in + 1'b1;
         end
         if (dot_seen_in) begin
            if (quad_ok_in && quad_groups_in == iatv_pkg::QUAD_GROUPS) begin
               verdict = iatv_pkg::VERDICT_QUAD;
            end
         end else if (colon_seen_in) begin
            if (hex_ok_in && hex_groups_in == iatv_pkg::HEX_GROUPS) begin
               verdict = iatv_pkg::VERDICT_HEX;
            end
         end
         dot_seen_in        = 1'b0;
         colon_seen_in      = 1'b0;
         quad_ok_in         = 1'b1;
         quad_groups_in     = '0;
         quad_digits_in     = '0;
         quad_value_in      = '0;
         quad_first_zero_in = 1'b0;
         hex_ok_in          = 1'b1;
         hex_groups_in      = '0;
         hex_digits_in      = '0;
      end

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_verdict_in = rsp_verdict_ff;
      if (take && tok.last) begin
         rsp_valid_in   = 1'b1;
         rsp_verdict_in = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_seen_ff        <= 1'b0;
         colon_seen_ff      <= 1'b0;
         quad_ok_ff         <= 1'b1;
         quad_groups_ff     <= '0;
         quad_digits_ff     <= '0;
         quad_value_ff      <= '0;
         quad_first_zero_ff <= 1'b0;
         hex_ok_ff          <= 1'b1;
         hex_groups_ff      <= '0;
         hex_digits_ff      <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (take) begin
            dot_seen_ff        <= dot_seen_in;
            colon_seen_ff      <= colon_seen_in;
            quad_ok_ff         <= quad_ok_in;
            quad_groups_ff     <= quad_groups_in;
            quad_digits_ff     <= quad_digits_in;
            quad_value_ff      <= quad_value_in;
            quad_first_zero_ff <= quad_first_zero_in;
            hex_ok_ff          <= hex_ok_in;
            hex_groups_ff      <= hex_groups_in;
            hex_digits_ff      <= hex_digits_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   `IATV_ASSERT_NEXT(a_clear_after_last, clock, reset, take && tok.last, quad_groups_ff == '0 && hex_groups_ff == '0 && !dot_seen_ff && !colon_seen_ff)
   `IATV_ASSERT_IMPLY(a_verdict_code, clock, reset, rsp_valid_ff, rsp_verdict_ff != 2'd3)

endmodule

// ===== rtl/ip_address_text_validator.sv =====
// channel   beat holds                        handshake
// req       req_char_code, req_last_char      req_valid / req_ready
// rsp       rsp_verdict                       rsp_valid / rsp_ready
//
// one character per clock sustained while rsp is not stalled
// a verdict passes the classify register, one queue slot and the result register
// synchronous active-high reset clears the classify valid flag, the queue, the string state and the result valid flag
// a stalled rsp fills the result register, then the queue, then the classify stage

module ip_address_text_validator #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_verdict
);

   iatv_pkg::token_type front_tok, back_tok;
   logic                front_valid, front_ready;
   logic                back_valid, back_ready;

   iatv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .tok_valid     (front_valid),
      .tok_ready     (front_ready),
      .tok           (front_tok)
   );

   iatv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_tok   (front_tok),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_tok    (back_tok)
   );

   iatv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .tok_valid   (back_valid),
      .tok_ready   (back_ready),
      .tok         (back_tok),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_verdict (rsp_verdict)
   );

endmodule
